// ===== hdl/assert_macros.svh =====
// Assertion helpers for the combiner.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define CRT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked on every clock edge outside reset.
`define CRT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/crt_pkg.sv =====
`default_nettype none
package crt_pkg;
    // Datapath width of the divider: 64-bit dividend for modular reductions.
    localparam int DivWidth = 64;

    // Request to the shared divider.
    typedef struct packed {
        logic                start;
        logic [DivWidth-1:0] dividend;
        logic [DivWidth-1:0] divisor;
    } div_req_t;

    // Response from the shared divider.
    typedef struct packed {
        logic                busy;
        logic                done;
        logic [DivWidth-1:0] quotient;
        logic [DivWidth-1:0] remainder;
    } div_rsp_t;
endpackage
`default_nettype wire

// ===== hdl/crt_divider.sv =====
`default_nettype none
// Restoring divider, one quotient bit per cycle.
module crt_divider (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire crt_pkg::div_req_t  req,
    output crt_pkg::div_rsp_t       rsp
);
    import crt_pkg::*;

    localparam int CntW = $clog2(DivWidth + 1);

    logic                busy_reg;
    logic                done_reg;
    logic [CntW-1:0]     cnt_reg;
    logic [DivWidth-1:0] quo_reg;
    logic [DivWidth-1:0] rem_reg;
    logic [DivWidth-1:0] den_reg;
    logic [DivWidth:0]   shifted;
    logic [DivWidth:0]   diff;

    // One restoring step
    always_comb
    begin
        shifted = {rem_reg, quo_reg[DivWidth-1]};
        diff    = shifted - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start && !busy_reg)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CntW'(DivWidth);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CntW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (req.start && !busy_reg)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            den_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (!diff[DivWidth])
            begin
                rem_reg <= diff[DivWidth-1:0];
                quo_reg <= {quo_reg[DivWidth-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= shifted[DivWidth-1:0];
                quo_reg <= {quo_reg[DivWidth-2:0], 1'b0};
            end
        end
    end

    assign rsp.busy      = busy_reg;
    assign rsp.done      = done_reg;
    assign rsp.quotient  = quo_reg;
    assign rsp.remainder = rem_reg;
endmodule
`default_nettype wire

// ===== hdl/crt_combiner_top.sv =====
`default_nettype none
// Channel   Direction  Handshake          Payload
// input     in         valid / ready      residue, modulus, last_pair
// output    out        out_valid/out_ready solution, product_overflow
//
// A pair without last_pair is stored. A last pair starts the combine (on
// overflow: zero solution, product_overflow set): per stored pair 9 divisions
// plus one per Euclid step (up to ~48), on the shared bit-serial divider.
// No item is taken while a set is combined or while its result waits.
// Reset clears control state only; the pair memories are written before read.
`include "assert_macros.svh"
module crt_combiner_top #(
    parameter int MAX_PAIRS   = 8,
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        valid,
    output logic             ready,
    input  wire logic [31:0] residue,
    input  wire logic [31:0] modulus,
    input  wire logic        last_pair,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [31:0]      solution,
    output logic             product_overflow
);
    import crt_pkg::*;

    localparam int IdxW = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam int CntW = $clog2(MAX_PAIRS + 1);
    localparam logic [63:0] ValMask = (64'd1 << VALUE_WIDTH) - 64'd1;

    // Sequencer states
    localparam logic [3:0] S_LOAD  = 4'd0;
    localparam logic [3:0] S_RD    = 4'd1;
    localparam logic [3:0] S_BIG   = 4'd2;
    localparam logic [3:0] S_R0    = 4'd3;
    localparam logic [3:0] S_EUC   = 4'd4;
    localparam logic [3:0] S_SMOD  = 4'd5;
    localparam logic [3:0] S_BMOD  = 4'd6;
    localparam logic [3:0] S_IMOD  = 4'd7;
    localparam logic [3:0] S_T1    = 4'd8;
    localparam logic [3:0] S_RMOD  = 4'd9;
    localparam logic [3:0] S_T2    = 4'd10;
    localparam logic [3:0] S_XMOD  = 4'd11;
    localparam logic [3:0] S_OUT   = 4'd12;

    logic [31:0] res_mem [MAX_PAIRS];
    logic [31:0] mod_mem [MAX_PAIRS];
    logic [31:0] res_rd_reg;
    logic [31:0] mod_rd_reg;

    logic [3:0]      state_reg;
    logic            wait_reg;
    logic [CntW-1:0] count_reg;
    logic [IdxW-1:0] idx_reg;
    logic [31:0]     prod_reg;
    logic            ovf_reg;
    logic [63:0]     big_reg;
    logic [63:0]     a_reg;
    logic [63:0]     r0_reg;
    logic [63:0]     r1_reg;
    logic signed [63:0] s0_reg;
    logic signed [63:0] s1_reg;
    logic [63:0]     x_reg;
    logic [31:0]     sol_reg;
    logic            flag_reg;

    div_req_t div_req;
    div_rsp_t div_rsp;

    logic [31:0] r_in;
    logic [31:0] m_in;
    logic [63:0] prod_wide;
    logic        accept;
    logic        store_ok;
    logic [63:0] p64;
    logic [63:0] s0_mag;
    logic signed [32:0] q_nar;
    logic signed [32:0] s1_nar;
    logic signed [65:0] q_prod;
    logic signed [63:0] q_s1;

    crt_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Input side
    assign r_in      = 32'(64'(residue) & ValMask);
    assign m_in      = 32'(64'(modulus) & ValMask);
    assign ready     = (state_reg == S_LOAD);
    assign accept    = valid && ready;
    assign prod_wide = 64'(prod_reg) * 64'(m_in);
    assign store_ok  = (m_in != 32'd0) && (count_reg < CntW'(MAX_PAIRS)) && !ovf_reg;
    assign p64       = 64'(prod_reg);
    assign s0_mag    = s0_reg[63] ? 64'(-s0_reg) : 64'(s0_reg);

    // Euclid quotients fit 32 bits and the coefficients stay within the modulus
    assign q_nar  = $signed({1'b0, div_rsp.quotient[31:0]});
    assign s1_nar = s1_reg[32:0];
    assign q_prod = q_nar * s1_nar;
    assign q_s1   = q_prod[63:0];

    // Pair memories
    always_ff @(posedge clk)
    begin
        if (accept && store_ok)
        begin
            res_mem[count_reg[IdxW-1:0]] <= r_in;
            mod_mem[count_reg[IdxW-1:0]] <= m_in;
        end
        res_rd_reg <= res_mem[idx_reg];
        mod_rd_reg <= mod_mem[idx_reg];
    end

    // Divider launch: one request per entry of a dividing state, one per step in S_EUC
    always_comb
    begin
        div_req.start    = 1'b0;
        div_req.dividend = '0;
        div_req.divisor  = 64'd1;
        if (!wait_reg)
        begin
            case (state_reg)
                S_BIG:
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = p64;
                    div_req.divisor = 64'(mod_rd_reg);
                end
                S_R0:
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = big_reg;
                    div_req.divisor = 64'(mod_rd_reg);
                end
                S_EUC:
                begin
                    div_req.start = (r1_reg != 64'd0);
                    div_req.dividend = r0_reg;
                    div_req.divisor = (r1_reg != 64'd0) ? r1_reg : 64'd1;
                end
                S_SMOD:
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = s0_mag;
                    div_req.divisor = 64'(mod_rd_reg);
                end
                S_BMOD:
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = big_reg;
                    div_req.divisor = p64;
                end
                S_IMOD, S_T1, S_RMOD, S_T2, S_XMOD:
                begin
                    div_req.start = 1'b1;
                    div_req.dividend = a_reg;
                    div_req.divisor = p64;
                end
                default:
                begin
                    div_req.start = 1'b0;
                end
            endcase
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_LOAD;
            wait_reg  <= 1'b0;
            count_reg <= '0;
            idx_reg   <= '0;
            prod_reg  <= 32'd1;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            if (div_req.start)
            begin
                wait_reg <= 1'b1;
            end
            case (state_reg)
                S_LOAD:
                begin
                    if (accept)
                    begin
                        if (m_in == 32'd0 || count_reg >= CntW'(MAX_PAIRS))
                        begin
                            ovf_reg <= 1'b1;
                        end
                        else if (!ovf_reg)
                        begin
                            count_reg <= count_reg + 1'b1;
                            if (prod_wide > ValMask)
                            begin
                                ovf_reg <= 1'b1;
                            end
                            else
                            begin
                                prod_reg <= prod_wide[31:0];
                            end
                        end
                        if (last_pair)
                        begin
                            idx_reg <= '0;
                            x_reg   <= 64'd0;
                            if (ovf_reg || !store_ok || prod_wide > ValMask)
                            begin
                                sol_reg  <= 32'd0;
                                flag_reg <= 1'b1;
                                state_reg <= S_OUT;
                            end
                            else
                            begin
                                flag_reg  <= 1'b0;
                                state_reg <= S_RD;
                            end
                        end
                    end
                end
                S_RD:
                begin
                    state_reg <= S_BIG;
                end
                S_BIG:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        big_reg   <= div_rsp.quotient;
                        state_reg <= S_R0;
                    end
                end
                S_R0:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        r0_reg    <= div_rsp.remainder;
                        r1_reg    <= 64'(mod_rd_reg);
                        s0_reg    <= 64'sd1;
                        s1_reg    <= 64'sd0;
                        state_reg <= S_EUC;
                    end
                end
                S_EUC:
                begin
                    if (!wait_reg && r1_reg == 64'd0)
                    begin
                        state_reg <= S_SMOD;
                    end
                    else if (div_rsp.done)
                    begin
                        wait_reg <= 1'b0;
                        r0_reg   <= r1_reg;
                        r1_reg   <= div_rsp.remainder;
                        s0_reg   <= s1_reg;
                        s1_reg   <= s0_reg - q_s1;
                    end
                end
                S_SMOD:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg <= 1'b0;
                        if (r0_reg != 64'd1)
                        begin
                            a_reg <= 64'd0;
                        end
                        else if (s0_reg[63] && div_rsp.remainder != 64'd0)
                        begin
                            a_reg <= 64'(mod_rd_reg) - div_rsp.remainder;
                        end
                        else
                        begin
                            a_reg <= div_rsp.remainder;
                        end
                        state_reg <= S_BMOD;
                    end
                end
                S_BMOD:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        big_reg   <= div_rsp.remainder;
                        state_reg <= S_IMOD;
                    end
                end
                S_IMOD:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        a_reg     <= 64'(big_reg[31:0]) * 64'(div_rsp.remainder[31:0]);
                        state_reg <= S_T1;
                    end
                end
                S_T1:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        big_reg   <= div_rsp.remainder;
                        a_reg     <= 64'(res_rd_reg);
                        state_reg <= S_RMOD;
                    end
                end
                S_RMOD:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        a_reg     <= 64'(div_rsp.remainder[31:0]) * 64'(big_reg[31:0]);
                        state_reg <= S_T2;
                    end
                end
                S_T2:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg  <= 1'b0;
                        a_reg     <= x_reg + div_rsp.remainder;
                        state_reg <= S_XMOD;
                    end
                end
                S_XMOD:
                begin
                    if (div_rsp.done)
                    begin
                        wait_reg <= 1'b0;
                        x_reg    <= div_rsp.remainder;
                        if (CntW'(idx_reg) + 1'b1 >= count_reg)
                        begin
                            sol_reg   <= div_rsp.remainder[31:0];
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            idx_reg   <= idx_reg + 1'b1;
                            state_reg <= S_RD;
                        end
                    end
                end
                S_OUT:
                begin
                    if (out_ready)
                    begin
                        count_reg <= '0;
                        prod_reg  <= 32'd1;
                        ovf_reg   <= 1'b0;
                        state_reg <= S_LOAD;
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

    assign out_valid        = (state_reg == S_OUT);
    assign solution         = sol_reg;
    assign product_overflow = flag_reg;

    `CRT_ASSERT_IMP(a_no_accept_busy, clk, rst_n, state_reg != S_LOAD, !accept, "accept while combining")
    `CRT_ASSERT_NEXT(a_out_returns, clk, rst_n, out_valid && out_ready, state_reg == S_LOAD, "no return to load after transfer")
    `CRT_ASSERT_IMP(a_ovf_zero, clk, rst_n, out_valid && product_overflow, solution == 32'd0, "overflow with nonzero solution")
endmodule
`default_nettype wire
